[src/stt_pkg.sv]
// ----------------------------------------------------------------------------
// stt_pkg: shared types and constants for the sparse triplet table
// Entry layout, request and result records, operation and status codes.
// ----------------------------------------------------------------------------
package stt_pkg;

  localparam int unsigned ROW_W   = 8;
  localparam int unsigned COL_W   = 8;
  localparam int unsigned VAL_W   = 32;
  localparam int unsigned OP_W    = 2;
  localparam int unsigned STAT_W  = 2;

  localparam int unsigned CAPACITY = 64;
  localparam int unsigned IDX_W    = $clog2(CAPACITY);
  localparam int unsigned CNT_W    = $clog2(CAPACITY + 1);

  localparam int unsigned MAX_ROWS = 256;
  localparam int unsigned MAX_COLS = 256;
  // wide enough to hold either coordinate limit
  localparam int unsigned LIM_W    = 17;

  localparam logic [OP_W-1:0] OP_ADD    = 2'd0;
  localparam logic [OP_W-1:0] OP_REMOVE = 2'd1;
  localparam logic [OP_W-1:0] OP_FIND   = 2'd2;
  localparam logic [OP_W-1:0] OP_CHANGE = 2'd3;

  localparam logic [STAT_W-1:0] STAT_OK   = 2'd0;
  localparam logic [STAT_W-1:0] STAT_ZERO = 2'd1;
  localparam logic [STAT_W-1:0] STAT_NONE = 2'd2;
  localparam logic [STAT_W-1:0] STAT_FAIL = 2'd3;

  typedef struct packed {
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
    logic [VAL_W-1:0] value;
  } entry_t;

  typedef struct packed {
    logic [OP_W-1:0]  op;
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
    logic [VAL_W-1:0] value;
    logic [IDX_W-1:0] position;
  } req_t;

  typedef struct packed {
    logic [VAL_W-1:0]  found_value;
    logic [STAT_W-1:0] status;
    logic [CNT_W-1:0]  count;
  } res_t;

  typedef struct packed {
    logic             en;
    logic [IDX_W-1:0] addr;
    entry_t           data;
  } mem_wr_t;

endpackage

[src/stt_mem.sv]
// ----------------------------------------------------------------------------
// stt_mem: entry store
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module stt_mem (
  input  logic                         clk_i,
  input  stt_pkg::mem_wr_t             wr_i,
  input  logic [stt_pkg::IDX_W-1:0]    rd_addr_i,
  output stt_pkg::entry_t              rd_data_o
);

  stt_pkg::entry_t mem_q [stt_pkg::CAPACITY];
  stt_pkg::entry_t rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem_q[wr_i.addr] <= wr_i.data;
    end
    rd_data_q <= mem_q[rd_addr_i];
  end

  assign rd_data_o = rd_data_q;

endmodule

[src/stt_match.sv]
// ----------------------------------------------------------------------------
// stt_match: coordinate compare unit
// Compares one stored entry against the requested row and column.
// ----------------------------------------------------------------------------
module stt_match (
  input  stt_pkg::entry_t              entry_i,
  input  logic [stt_pkg::ROW_W-1:0]    row_i,
  input  logic [stt_pkg::COL_W-1:0]    col_i,
  output logic                         hit_o,
  output logic                         zero_o
);

  assign hit_o  = (entry_i.row == row_i) && (entry_i.col == col_i);
  assign zero_o = (entry_i.value == '0);

endmodule

[src/stt_ctrl.sv]
// ----------------------------------------------------------------------------
// stt_ctrl: request sequencer
// Runs add, remove, find and change over the store, one entry per cycle.
// ----------------------------------------------------------------------------
module stt_ctrl (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         req_valid_i,
  output logic                         req_ready_o,
  input  stt_pkg::req_t                req_i,
  output logic                         res_valid_o,
  input  logic                         res_ready_i,
  output stt_pkg::res_t                res_o,
  output stt_pkg::mem_wr_t             mem_wr_o,
  output logic [stt_pkg::IDX_W-1:0]    mem_rd_addr_o,
  input  stt_pkg::entry_t              mem_rd_data_i
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_EXEC = 2'd1;
  localparam logic [1:0] S_SCAN = 2'd2;
  localparam logic [1:0] S_DONE = 2'd3;

  logic [1:0]                  state_q, state_d;
  stt_pkg::req_t               req_q, req_d;
  logic [stt_pkg::CNT_W-1:0]   cnt_q, cnt_d;
  logic [stt_pkg::CNT_W-1:0]   rd_q, rd_d;
  logic                        pend_q, pend_d;
  logic [stt_pkg::IDX_W-1:0]   pend_idx_q, pend_idx_d;
  logic [stt_pkg::VAL_W-1:0]   found_q, found_d;
  logic [stt_pkg::STAT_W-1:0]  status_q, status_d;
  logic                        hit, zero, finish, coord_ok;

  stt_match u_match (
    .entry_i (mem_rd_data_i),
    .row_i   (req_q.row),
    .col_i   (req_q.col),
    .hit_o   (hit),
    .zero_o  (zero)
  );

  assign coord_ok = (stt_pkg::LIM_W'(req_q.row) < stt_pkg::LIM_W'(stt_pkg::MAX_ROWS)) &&
                    (stt_pkg::LIM_W'(req_q.col) < stt_pkg::LIM_W'(stt_pkg::MAX_COLS));

  always_comb begin
    state_d       = state_q;
    req_d         = req_q;
    cnt_d         = cnt_q;
    rd_d          = rd_q;
    pend_d        = pend_q;
    pend_idx_d    = pend_idx_q;
    found_d       = found_q;
    status_d      = status_q;
    finish        = 1'b0;
    req_ready_o   = 1'b0;
    res_valid_o   = 1'b0;
    mem_wr_o      = '0;
    mem_rd_addr_o = rd_q[stt_pkg::IDX_W-1:0];

    unique case (state_q)
      S_IDLE: begin
        req_ready_o = 1'b1;
        if (req_valid_i) begin
          req_d   = req_i;
          state_d = S_EXEC;
        end
      end

      S_EXEC: begin
        found_d  = '0;
        status_d = stt_pkg::STAT_OK;
        pend_d   = 1'b0;
        unique case (req_q.op)
          stt_pkg::OP_ADD: begin
            state_d = S_DONE;
            if ((cnt_q < stt_pkg::CNT_W'(stt_pkg::CAPACITY)) && coord_ok) begin
              mem_wr_o.en         = 1'b1;
              mem_wr_o.addr       = cnt_q[stt_pkg::IDX_W-1:0];
              mem_wr_o.data.row   = req_q.row;
              mem_wr_o.data.col   = req_q.col;
              mem_wr_o.data.value = req_q.value;
              cnt_d               = cnt_q + 1'b1;
            end else begin
              status_d = stt_pkg::STAT_FAIL;
            end
          end
          stt_pkg::OP_REMOVE: begin
            if (stt_pkg::CNT_W'(req_q.position) >= cnt_q) begin
              status_d = stt_pkg::STAT_FAIL;
              state_d  = S_DONE;
            end else begin
              // shift starts with the entry just above the hole
              rd_d    = stt_pkg::CNT_W'(req_q.position) + 1'b1;
              state_d = S_SCAN;
            end
          end
          default: begin
            rd_d    = '0;
            state_d = S_SCAN;
          end
        endcase
      end

      S_SCAN: begin
        if (pend_q) begin
          if (req_q.op == stt_pkg::OP_REMOVE) begin
            mem_wr_o.en   = 1'b1;
            mem_wr_o.addr = pend_idx_q - 1'b1;
            mem_wr_o.data = mem_rd_data_i;
          end else if (hit) begin
            finish = 1'b1;
            if (req_q.op == stt_pkg::OP_FIND) begin
              if (zero) begin
                found_d  = '1;
                status_d = stt_pkg::STAT_ZERO;
              end else begin
                found_d = mem_rd_data_i.value;
              end
            end else begin
              mem_wr_o.en         = 1'b1;
              mem_wr_o.addr       = pend_idx_q;
              mem_wr_o.data.row   = req_q.row;
              mem_wr_o.data.col   = req_q.col;
              mem_wr_o.data.value = req_q.value;
            end
          end
        end else if (rd_q >= cnt_q) begin
          finish = 1'b1;
          if (req_q.op == stt_pkg::OP_REMOVE) begin
            cnt_d = cnt_q - 1'b1;
          end else begin
            status_d = stt_pkg::STAT_NONE;
          end
        end

        if (finish) begin
          pend_d  = 1'b0;
          state_d = S_DONE;
        end else if (rd_q < cnt_q) begin
          rd_d       = rd_q + 1'b1;
          pend_d     = 1'b1;
          pend_idx_d = rd_q[stt_pkg::IDX_W-1:0];
        end else begin
          pend_d = 1'b0;
        end
      end

      S_DONE: begin
        res_valid_o = 1'b1;
        if (res_ready_i) begin
          state_d = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign res_o.found_value = found_q;
  assign res_o.status      = status_q;
  assign res_o.count       = cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
      pend_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      pend_q  <= pend_d;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q      <= req_d;
    rd_q       <= rd_d;
    pend_idx_q <= pend_idx_d;
    found_q    <= found_d;
    status_q   <= status_d;
  end

endmodule

[src/sparse_triplet_table.sv]
// ----------------------------------------------------------------------------
// sparse_triplet_table: coordinate-list sparse-matrix table
// Holds up to 64 (row, column, value) entries; add, remove, find, change.
// ----------------------------------------------------------------------------
// Usage:
//  - Requests arrive on the s_axis channel: tuser carries the operation,
//    tdata the row, column, value and position. Each request gives exactly
//    one result on the m_axis channel: tuser carries the status, tdata the
//    found value and the entry count after the operation.
//  - One request is handled at a time; s_axis_tready is low from acceptance
//    until the result has been handed to the output register.
//  - An add or a rejected remove goes from acceptance through the execute
//    state straight to the result state. Find and change walk the store
//    from entry 0, one entry per cycle through the single read port, and
//    stop at the first match or at the end of the table. Remove moves
//    each later entry down one place per cycle.
//  - The single read port of the entry store and its registered read data
//    set the pace: one entry per cycle.
//  - Reset empties the table at once (count to zero); no clearing pass.
//  - A stalled receiver holds the result in the output register; the next
//    request may be accepted meanwhile, and its result waits until the
//    register frees.
// ----------------------------------------------------------------------------
module sparse_triplet_table (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [55:0] s_axis_tdata,   // row[7:0], col[15:8], value[47:16],
                                      // position[53:48], zero pad[55:54]
  input  logic [1:0]  s_axis_tuser,   // op[1:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,   // found_value[31:0], count[38:32],
                                      // zero pad[39]
  output logic [1:0]  m_axis_tuser    // status[1:0]
);

  stt_pkg::req_t                 req;
  stt_pkg::res_t                 res;
  stt_pkg::res_t                 out_q;
  logic                          out_valid_q;
  logic                          res_valid, res_ready;
  stt_pkg::mem_wr_t              mem_wr;
  logic [stt_pkg::IDX_W-1:0]     mem_rd_addr;
  stt_pkg::entry_t               mem_rd_data;

  // unpack the request
  assign req.op       = s_axis_tuser;
  assign req.row      = s_axis_tdata[7:0];
  assign req.col      = s_axis_tdata[15:8];
  assign req.value    = s_axis_tdata[47:16];
  assign req.position = s_axis_tdata[53:48];

  stt_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .req_valid_i   (s_axis_tvalid),
    .req_ready_o   (s_axis_tready),
    .req_i         (req),
    .res_valid_o   (res_valid),
    .res_ready_i   (res_ready),
    .res_o         (res),
    .mem_wr_o      (mem_wr),
    .mem_rd_addr_o (mem_rd_addr),
    .mem_rd_data_i (mem_rd_data)
  );

  stt_mem u_mem (
    .clk_i     (clk_i),
    .wr_i      (mem_wr),
    .rd_addr_i (mem_rd_addr),
    .rd_data_o (mem_rd_data)
  );

  // output register: frees when empty or when the receiver takes the result
  assign res_ready = !out_valid_q || m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_ready) begin
      out_valid_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_ready && res_valid) begin
      out_q <= res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {1'b0, out_q.count, out_q.found_value};
  assign m_axis_tuser  = out_q.status;

endmodule

[src/sparse_triplet_table_chk.sv]
// ----------------------------------------------------------------------------
// sparse_triplet_table_chk: port-level checks
// Result channel behaviour and result field consistency.
// ----------------------------------------------------------------------------
module sparse_triplet_table_chk (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [39:0] m_axis_tdata,
  input  logic [1:0]  m_axis_tuser
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("result changed while stalled");

  // one request at a time: busy straight after acceptance
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("request accepted while busy");

  // count never exceeds capacity
  a_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[38:32] <= 7'd64)
    else $error("count above capacity");

  // stored zero reports all ones, failures report zero
  a_found: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |->
      ((m_axis_tuser == stt_pkg::STAT_ZERO) && (m_axis_tdata[31:0] == 32'hFFFF_FFFF)) ||
      ((m_axis_tuser == stt_pkg::STAT_NONE) && (m_axis_tdata[31:0] == 32'd0)) ||
      ((m_axis_tuser == stt_pkg::STAT_FAIL) && (m_axis_tdata[31:0] == 32'd0)) ||
      (m_axis_tuser == stt_pkg::STAT_OK))
    else $error("found value inconsistent with status");

endmodule

bind sparse_triplet_table sparse_triplet_table_chk u_chk (.*);

[tb/stt_reply_checker.sv]
// ----------------------------------------------------------------------------
// stt_reply_checker: result checker for the sparse triplet table
// Watches both stream channels, keeps its own copy of the entry table,
// predicts one result per accepted request and compares results in order.
// ----------------------------------------------------------------------------
module stt_reply_checker
  import stt_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               s_axis_tvalid,
  input  logic               s_axis_tready,
  input  logic [55:0]        s_axis_tdata,
  input  logic [1:0]         s_axis_tuser,
  input  logic               m_axis_tvalid,
  input  logic               m_axis_tready,
  input  logic [39:0]        m_axis_tdata,
  input  logic [1:0]         m_axis_tuser,
  output int unsigned        fail_count_o,
  output int unsigned        pending_o
);

  entry_t          mirror_entries [CAPACITY];
  logic [CNT_W-1:0] mirror_count;
  res_t            table_reply_q [$];
  int unsigned     mismatch_count = 0;
  int unsigned     replies_waiting = 0;

  assign fail_count_o = mismatch_count;
  assign pending_o    = replies_waiting;

  task automatic report_mismatch(input string what);
    if (mismatch_count < 40) $display("%0t: mismatch: %s", $time, what);
    mismatch_count++;
  endtask

  // Applies one request to the mirrored table and gives the result it owes.
  task automatic apply_table_op(input req_t rq, output res_t rs);
    int hit;
    int unsigned i;
    hit = -1;
    rs  = '0;
    rs.status = STAT_OK;
    if (rq.op == OP_FIND || rq.op == OP_CHANGE) begin
      for (i = 0; i < 32'(mirror_count); i++) begin
        if (hit < 0 && mirror_entries[IDX_W'(i)].row == rq.row &&
            mirror_entries[IDX_W'(i)].col == rq.col)
          hit = int'(i);
      end
    end
    case (rq.op)
      OP_ADD: begin
        if (mirror_count >= CNT_W'(CAPACITY) || 32'(rq.row) >= MAX_ROWS ||
            32'(rq.col) >= MAX_COLS) begin
          rs.status = STAT_FAIL;
        end else begin
          mirror_entries[IDX_W'(mirror_count)] = '{row: rq.row, col: rq.col, value: rq.value};
          mirror_count++;
        end
      end
      OP_REMOVE: begin
        if (CNT_W'(rq.position) >= mirror_count) begin
          rs.status = STAT_FAIL;
        end else begin
          for (i = 32'(rq.position); i + 1 < 32'(mirror_count); i++)
            mirror_entries[IDX_W'(i)] = mirror_entries[IDX_W'(i + 1)];
          mirror_count--;
        end
      end
      OP_FIND: begin
        if (hit < 0) begin
          rs.status = STAT_NONE;
        end else if (mirror_entries[IDX_W'(hit)].value != '0) begin
          rs.found_value = mirror_entries[IDX_W'(hit)].value;
        end else begin
          // stored zero reads back as minus one
          rs.status      = STAT_ZERO;
          rs.found_value = '1;
        end
      end
      default: begin
        if (hit < 0) rs.status = STAT_NONE;
        else mirror_entries[IDX_W'(hit)].value = rq.value;
      end
    endcase
    rs.count = mirror_count;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    req_t rq;
    res_t want;
    if (!rst_ni) begin
      mirror_count = '0;
      table_reply_q.delete();
      replies_waiting = 0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        rq.op       = s_axis_tuser;
        rq.row      = s_axis_tdata[7:0];
        rq.col      = s_axis_tdata[15:8];
        rq.value    = s_axis_tdata[47:16];
        rq.position = s_axis_tdata[53:48];
        apply_table_op(rq, want);
        table_reply_q.push_back(want);
      end
      if (m_axis_tvalid && m_axis_tready) begin
        if (table_reply_q.size() == 0) begin
          report_mismatch("result with no request outstanding");
        end else begin
          want = table_reply_q.pop_front();
          if (m_axis_tdata[31:0] !== want.found_value)
            report_mismatch($sformatf("found_value got %h want %h",
                                      m_axis_tdata[31:0], want.found_value));
          if (m_axis_tuser !== want.status)
            report_mismatch($sformatf("status got %0d want %0d",
                                      m_axis_tuser, want.status));
          if (m_axis_tdata[38:32] !== want.count)
            report_mismatch($sformatf("count got %0d want %0d",
                                      m_axis_tdata[38:32], want.count));
        end
      end
      replies_waiting = table_reply_q.size();
    end
  end

endmodule

[tb/tb_sparse_triplet_table.sv]
// ----------------------------------------------------------------------------
// tb_sparse_triplet_table: testbench top for the sparse triplet table
// Drives a directed opening and three random phases of add, remove, find and
// change requests with varying idle rates on both channels and one long
// receiver hold-off; the checker alongside predicts and compares results.
// ----------------------------------------------------------------------------
module tb_sparse_triplet_table;
  import stt_pkg::*;

  localparam int unsigned HOLD_CYCLES = 300;     // receiver back-pressure stretch
  localparam int unsigned CYCLE_LIMIT = 400000;  // far beyond the slowest good run
  localparam int unsigned TAIL_CYCLES = 100;     // > worst walk of a full table

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [55:0] s_axis_tdata = '0;   // row[7:0], col[15:8], value[47:16],
                                    // position[53:48], zero pad[55:54]
  logic [1:0]  s_axis_tuser = '0;   // op[1:0]
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [39:0] m_axis_tdata;        // found_value[31:0], count[38:32], pad[39]
  logic [1:0]  m_axis_tuser;        // status[1:0]

  int unsigned fail_count;
  int unsigned replies_pending;
  int unsigned cycle_count = 0;

  // idle rates in percent, changed per phase
  int unsigned send_idle_pct = 19;
  int unsigned recv_idle_pct = 67;
  bit          pressure_go   = 1'b0;
  bit          pressure_done = 1'b0;

  // Stimulus-side estimate of the entry count, only used to aim removes.
  int unsigned table_fill = 0;

  always #5 clk_i = ~clk_i;

  sparse_triplet_table DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  stt_reply_checker u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .fail_count_o  (fail_count),
    .pending_o     (replies_pending)
  );

  // Watchdog: a hung handshake or a missing result ends here.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // Result side. Ready toggles at random at the falling edge; once asked, it
  // holds off for a long stretch so the block backs up and drops s_axis_tready.
  initial begin
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (pressure_go && !pressure_done) begin
        m_axis_tready <= 1'b0;
        repeat (HOLD_CYCLES - 1) @(negedge clk_i);
        pressure_done = 1'b1;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // Offers one request, with random idle cycles first, and waits until taken.
  // Each falling edge carries at most one update of tvalid.
  task automatic offer_request(input logic [OP_W-1:0]  op,
                               input logic [ROW_W-1:0] row,
                               input logic [COL_W-1:0] col,
                               input logic [VAL_W-1:0] value,
                               input logic [IDX_W-1:0] pos);
    forever begin
      @(negedge clk_i);
      if ($urandom_range(99) >= send_idle_pct) break;
      s_axis_tvalid <= 1'b0;
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= {2'b00, pos, value, col, row};
    do @(posedge clk_i); while (!s_axis_tready);
    case (op)
      OP_ADD:    if (table_fill < CAPACITY) table_fill++;
      OP_REMOVE: if (32'(pos) < table_fill) table_fill--;
      default:   ;
    endcase
  endtask

  // Random requests with a given op mix (percent add, remove, find; the rest
  // change). Coordinates mostly come from a tiny pool so that finds and
  // changes hit, duplicates appear, and removes mostly land inside the table.
  task automatic random_burst(input int unsigned n, input int unsigned add_pct,
                              input int unsigned rem_pct, input int unsigned find_pct);
    int unsigned pick;
    logic [OP_W-1:0]  op;
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
    logic [VAL_W-1:0] value;
    logic [IDX_W-1:0] pos;
    repeat (n) begin
      pick = $urandom_range(99);
      if (pick < add_pct) op = OP_ADD;
      else if (pick < add_pct + rem_pct) op = OP_REMOVE;
      else if (pick < add_pct + rem_pct + find_pct) op = OP_FIND;
      else op = OP_CHANGE;
      row = ROW_W'(($urandom_range(3) != 0) ? $urandom_range(3) : $urandom_range(255));
      col = COL_W'(($urandom_range(3) != 0) ? $urandom_range(3) : $urandom_range(255));
      case ($urandom_range(19))
        0, 1:    value = '0;
        2:       value = 32'h8000_0000;
        3:       value = 32'h7fff_ffff;
        default: value = $urandom;
      endcase
      if (table_fill > 0 && $urandom_range(9) < 8) pos = IDX_W'($urandom_range(table_fill - 1));
      else pos = IDX_W'($urandom_range(CAPACITY - 1));
      offer_request(op, row, col, value, pos);
    end
  endtask

  // Fill to full (with adds refused at capacity), churn, then drain.
  task automatic random_phase();
    random_burst(100, 85, 5, 5);
    random_burst(100, 30, 25, 25);
    random_burst(80, 10, 70, 10);
  endtask

  initial begin
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed opening: empty table, value extremes, stored zero,
    // duplicates, bad positions and shifting removes.
    offer_request(OP_FIND,   8'd0,   8'd0,   32'd0,         6'd0);
    offer_request(OP_CHANGE, 8'd0,   8'd0,   32'd5,         6'd0);
    offer_request(OP_REMOVE, 8'd0,   8'd0,   32'd0,         6'd0);
    offer_request(OP_ADD,    8'd0,   8'd0,   32'h8000_0000, 6'd0);
    offer_request(OP_ADD,    8'd255, 8'd255, 32'h7fff_ffff, 6'd63);
    offer_request(OP_ADD,    8'd3,   8'd4,   32'd0,         6'd0);
    offer_request(OP_ADD,    8'd3,   8'd4,   32'd77,        6'd0);
    offer_request(OP_FIND,   8'd0,   8'd0,   32'd0,         6'd0);
    offer_request(OP_FIND,   8'd255, 8'd255, 32'd0,         6'd0);
    offer_request(OP_FIND,   8'd3,   8'd4,   32'd0,         6'd0);
    offer_request(OP_CHANGE, 8'd3,   8'd4,   32'hffff_ffff, 6'd0);
    offer_request(OP_FIND,   8'd3,   8'd4,   32'd0,         6'd0);
    offer_request(OP_CHANGE, 8'd255, 8'd255, 32'd0,         6'd0);
    offer_request(OP_FIND,   8'd255, 8'd255, 32'd0,         6'd0);
    offer_request(OP_CHANGE, 8'd255, 8'd255, 32'd9,         6'd0);
    offer_request(OP_FIND,   8'd4,   8'd3,   32'd0,         6'd0);
    offer_request(OP_REMOVE, 8'd0,   8'd0,   32'd0,         6'd4);
    offer_request(OP_REMOVE, 8'd0,   8'd0,   32'd0,         6'd63);
    offer_request(OP_REMOVE, 8'd0,   8'd0,   32'd0,         6'd0);
    offer_request(OP_FIND,   8'd0,   8'd0,   32'd0,         6'd0);
    offer_request(OP_REMOVE, 8'd0,   8'd0,   32'd0,         6'd2);
    offer_request(OP_FIND,   8'd3,   8'd4,   32'd0,         6'd0);

    // Phase one: slow receiver.
    random_phase();

    // Phase two: slow sender.
    send_idle_pct = 67;
    recv_idle_pct = 19;
    random_phase();

    // Phase three: no idling, opened by a long receiver hold-off while
    // requests keep coming.
    send_idle_pct = 0;
    recv_idle_pct = 0;
    pressure_go   = 1'b1;
    random_phase();

    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (replies_pending != 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);

    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
